FILE: rtl/core/s256_pkg.sv
// ----------------------------------------------------------------------------
// s256_pkg
// Shared types, constants and round functions of the SHA-256 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package s256_pkg;

    // Field widths of the streams
    localparam int unsigned DataW   = 32;
    localparam int unsigned CountW  = 3;
    localparam int unsigned IndexW  = 3;
    localparam int unsigned TdataW  = 40;   // 32 + 3 bits, padded to whole bytes

    // Block geometry
    localparam int unsigned WinDepth   = 16;   // message words per block
    localparam int unsigned HashWords  = 8;
    localparam int unsigned RoundIdxW  = 6;    // 64 rounds
    localparam logic [RoundIdxW-1:0] LastRound = 6'd63;
    localparam logic [5:0]  LastBlockPos = 6'd63;
    localparam logic [5:0]  PadEndPos    = 6'd55;  // last pad byte before length
    localparam logic [2:0]  MaxCount     = 3'd4;
    localparam logic [7:0]  PadMarker    = 8'h80;
    localparam logic [2:0]  LastIndex    = 3'd7;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DATA,
        S_PAD,
        S_LEN,
        S_COMP,
        S_FOLD,
        S_OUT
    } t_state;

    // Control from the sequencer to the datapath
    typedef struct packed {
        logic                 byte_we;    // one message, pad or length byte this cycle
        logic [7:0]           msg_byte;
        logic                 push;       // byte completes a word
        logic                 load_vars;  // a..h <= chaining words
        logic                 round_en;   // one compression round
        logic [RoundIdxW-1:0] round_idx;
        logic                 fold;       // chaining words += a..h
        logic                 reinit;     // chaining words <= initial values
        logic [IndexW-1:0]    out_idx;    // digest word on the output
    } t_ctl;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Initial hash values
    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        case (idx)
            3'd0:    init_hash = 32'h6a09e667;
            3'd1:    init_hash = 32'hbb67ae85;
            3'd2:    init_hash = 32'h3c6ef372;
            3'd3:    init_hash = 32'ha54ff53a;
            3'd4:    init_hash = 32'h510e527f;
            3'd5:    init_hash = 32'h9b05688c;
            3'd6:    init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    // Round constants
    function automatic logic [31:0] round_key(input logic [5:0] idx);
        case (idx)
            6'd0:  round_key = 32'h428a2f98;  6'd1:  round_key = 32'h71374491;
            6'd2:  round_key = 32'hb5c0fbcf;  6'd3:  round_key = 32'he9b5dba5;
            6'd4:  round_key = 32'h3956c25b;  6'd5:  round_key = 32'h59f111f1;
            6'd6:  round_key = 32'h923f82a4;  6'd7:  round_key = 32'hab1c5ed5;
            6'd8:  round_key = 32'hd807aa98;  6'd9:  round_key = 32'h12835b01;
            6'd10: round_key = 32'h243185be;  6'd11: round_key = 32'h550c7dc3;
            6'd12: round_key = 32'h72be5d74;  6'd13: round_key = 32'h80deb1fe;
            6'd14: round_key = 32'h9bdc06a7;  6'd15: round_key = 32'hc19bf174;
            6'd16: round_key = 32'he49b69c1;  6'd17: round_key = 32'hefbe4786;
            6'd18: round_key = 32'h0fc19dc6;  6'd19: round_key = 32'h240ca1cc;
            6'd20: round_key = 32'h2de92c6f;  6'd21: round_key = 32'h4a7484aa;
            6'd22: round_key = 32'h5cb0a9dc;  6'd23: round_key = 32'h76f988da;
            6'd24: round_key = 32'h983e5152;  6'd25: round_key = 32'ha831c66d;
            6'd26: round_key = 32'hb00327c8;  6'd27: round_key = 32'hbf597fc7;
            6'd28: round_key = 32'hc6e00bf3;  6'd29: round_key = 32'hd5a79147;
            6'd30: round_key = 32'h06ca6351;  6'd31: round_key = 32'h14292967;
            6'd32: round_key = 32'h27b70a85;  6'd33: round_key = 32'h2e1b2138;
            6'd34: round_key = 32'h4d2c6dfc;  6'd35: round_key = 32'h53380d13;
            6'd36: round_key = 32'h650a7354;  6'd37: round_key = 32'h766a0abb;
            6'd38: round_key = 32'h81c2c92e;  6'd39: round_key = 32'h92722c85;
            6'd40: round_key = 32'ha2bfe8a1;  6'd41: round_key = 32'ha81a664b;
            6'd42: round_key = 32'hc24b8b70;  6'd43: round_key = 32'hc76c51a3;
            6'd44: round_key = 32'hd192e819;  6'd45: round_key = 32'hd6990624;
            6'd46: round_key = 32'hf40e3585;  6'd47: round_key = 32'h106aa070;
            6'd48: round_key = 32'h19a4c116;  6'd49: round_key = 32'h1e376c08;
            6'd50: round_key = 32'h2748774c;  6'd51: round_key = 32'h34b0bcb5;
            6'd52: round_key = 32'h391c0cb3;  6'd53: round_key = 32'h4ed8aa4a;
            6'd54: round_key = 32'h5b9cca4f;  6'd55: round_key = 32'h682e6ff3;
            6'd56: round_key = 32'h748f82ee;  6'd57: round_key = 32'h78a5636f;
            6'd58: round_key = 32'h84c87814;  6'd59: round_key = 32'h8cc70208;
            6'd60: round_key = 32'h90befffa;  6'd61: round_key = 32'ha4506ceb;
            6'd62: round_key = 32'hbef9a3f7;
            default: round_key = 32'hc67178f2;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/s256_ctrl.sv
// ----------------------------------------------------------------------------
// s256_ctrl
// Sequencer: feeds message, pad and length bytes one per cycle unless a block
// compresses, runs 64 rounds per full block and gives the eight digest words.
// ----------------------------------------------------------------------------
`default_nettype none

module s256_ctrl
    import s256_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input item
    input  wire logic              i_in_valid,
    input  wire logic [DataW-1:0]  i_data_word,
    input  wire logic [CountW-1:0] i_byte_count,
    input  wire logic              i_last_word,
    output logic                   o_in_ready,
    // result items
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    // datapath control
    output t_ctl                   o_ctl
);

    t_state               r_state, n_state;
    t_state               r_resume, n_resume;
    logic [2:0]           r_k, n_k;
    logic [CountW-1:0]    r_cnt, n_cnt;
    logic                 r_last, n_last;
    logic [DataW-1:0]     r_data, n_data;
    logic [5:0]           r_pos, n_pos;
    logic [63:0]          r_bytes, n_bytes;
    logic [RoundIdxW-1:0] r_round, n_round;
    logic                 r_pad_first, n_pad_first;

    logic [DataW-1:0]     w_data_sh;
    logic [63:0]          w_len_bits;
    logic [63:0]          w_len_sh;
    logic [CountW-1:0]    w_cnt_clamp;
    logic [2:0]           w_k_inc;
    t_state               w_follow;

    assign w_data_sh   = r_data << {r_k[1:0], 3'b000};
    assign w_len_bits  = {r_bytes[60:0], 3'b000};
    assign w_len_sh    = w_len_bits << {r_k, 3'b000};
    assign w_cnt_clamp = (i_byte_count > MaxCount) ? MaxCount : i_byte_count;
    assign w_k_inc     = r_k + 3'd1;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_resume    <= S_IDLE;
            r_k         <= '0;
            r_pos       <= '0;
            r_bytes     <= '0;
            r_round     <= '0;
            r_pad_first <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_resume    <= n_resume;
            r_k         <= n_k;
            r_pos       <= n_pos;
            r_bytes     <= n_bytes;
            r_round     <= n_round;
            r_pad_first <= n_pad_first;
        end
    end

    // Latched item payload
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_last <= n_last;
        r_data <= n_data;
    end

    // Next state and control
    always_comb begin
        n_state     = r_state;
        n_resume    = r_resume;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_data      = r_data;
        n_pos       = r_pos;
        n_bytes     = r_bytes;
        n_round     = r_round;
        n_pad_first = r_pad_first;
        w_follow    = r_state;

        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctl       = '0;
        o_ctl.round_idx = r_round;
        o_ctl.out_idx   = r_k;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_data      = i_data_word;
                    n_cnt       = w_cnt_clamp;
                    n_last      = i_last_word;
                    n_k         = '0;
                    n_pad_first = 1'b1;
                    if (w_cnt_clamp != '0) begin
                        n_state = S_DATA;
                    end else if (i_last_word) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_DATA: begin
                o_ctl.byte_we  = 1'b1;
                o_ctl.msg_byte = w_data_sh[31:24];
                n_bytes        = r_bytes + 64'd1;
                n_k            = w_k_inc;
                if (w_k_inc == r_cnt) begin
                    w_follow = r_last ? S_PAD : S_IDLE;
                end else begin
                    w_follow = S_DATA;
                end
            end
            S_PAD: begin
                o_ctl.byte_we  = 1'b1;
                o_ctl.msg_byte = r_pad_first ? PadMarker : 8'h00;
                n_pad_first    = 1'b0;
                n_k            = '0;
                w_follow       = (r_pos == PadEndPos) ? S_LEN : S_PAD;
            end
            S_LEN: begin
                o_ctl.byte_we  = 1'b1;
                o_ctl.msg_byte = w_len_sh[63:56];
                n_k            = w_k_inc;
                w_follow       = (r_k == LastIndex) ? S_OUT : S_LEN;
            end
            S_COMP: begin
                o_ctl.round_en = 1'b1;
                n_round        = r_round + 6'd1;
                if (r_round == LastRound) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_ctl.fold = 1'b1;
                n_state    = r_resume;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_k = w_k_inc;
                    if (r_k == LastIndex) begin
                        o_ctl.reinit = 1'b1;
                        n_bytes      = '0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Common byte write: advance block position, compress on a full block
        if (o_ctl.byte_we) begin
            o_ctl.push = (r_pos[1:0] == 2'b11);
            n_pos      = r_pos + 6'd1;
            if (r_pos == LastBlockPos) begin
                o_ctl.load_vars = 1'b1;
                n_round         = '0;
                n_resume        = w_follow;
                n_state         = S_COMP;
            end else begin
                n_state = w_follow;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/s256_sched.sv
// ----------------------------------------------------------------------------
// s256_sched
// Message schedule: packs bytes into words and keeps a sixteen-word window
// that shifts once per round and extends itself with the schedule recurrence.
// ----------------------------------------------------------------------------
`default_nettype none

module s256_sched
    import s256_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_ctl       i_ctl,
    output logic [31:0]     o_w
);

    logic [23:0] r_word;                    // up to three pending bytes
    logic [31:0] r_win [WinDepth];
    logic [31:0] w_full;
    logic [31:0] w_next;

    assign w_full = {r_word, i_ctl.msg_byte};
    assign w_next = r_win[0] + small_sigma0(r_win[1]) + r_win[9] + small_sigma1(r_win[14]);
    assign o_w    = r_win[0];

    // Byte packer
    always_ff @(posedge i_clk) begin
        if (i_ctl.byte_we) begin
            r_word <= w_full[23:0];
        end
    end

    // Schedule window
    always_ff @(posedge i_clk) begin
        if ((i_ctl.byte_we && i_ctl.push) || i_ctl.round_en) begin
            for (int i = 0; i < WinDepth - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WinDepth-1] <= i_ctl.round_en ? w_next : w_full;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/s256_round.sv
// ----------------------------------------------------------------------------
// s256_round
// Compression round unit: working variables a..h, one round per cycle, and
// the chaining words that are folded after each block.
// ----------------------------------------------------------------------------
`default_nettype none

module s256_round
    import s256_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_ctl       i_ctl,
    input  wire logic [31:0] i_w,
    output logic [31:0]     o_digest
);

    logic [31:0] r_h [HashWords];
    logic [31:0] r_v [HashWords];
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_ch;
    logic [31:0] w_maj;

    assign w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1  = r_v[7] + big_sigma1(r_v[4]) + w_ch
                 + round_key(i_ctl.round_idx) + i_w;
    assign w_t2  = big_sigma0(r_v[0]) + w_maj;

    assign o_digest = r_h[i_ctl.out_idx];

    // Working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_vars) begin
            for (int i = 0; i < HashWords; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_ctl.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    // Chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.reinit) begin
            for (int i = 0; i < HashWords; i++) begin
                r_h[i] <= init_hash(3'(i));
            end
        end else if (i_ctl.fold) begin
            for (int i = 0; i < HashWords; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sha256_hash_engine.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine
// SHA-256 over a byte stream of big-endian words; emits the eight digest
// words after the last item of each message.
// ----------------------------------------------------------------------------
// Channel   Direction  Fields (tdata from bit 0)                  tlast
// s_axis    in         data_word[31:0], byte_count[34:32]         last_word
// m_axis    out        digest_word[31:0], word_index[34:32]       last_digest
//
// An item is accepted, then its valid bytes are written (a count above four
// is taken as four). Every completed 64-byte block runs 64 rounds through
// the single round unit and then folds the working variables into the
// chaining words. A last item is followed by the padding bytes and eight
// length bytes, then each digest word is held until the sink takes it.
// Reset (synchronous, active low) restores the initial hash values.
// s_axis_tready is high only while the engine is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_hash_engine
    import s256_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // message words
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [TdataW-1:0] s_axis_tdata,   // data_word, byte_count, zero pad
    input  wire logic              s_axis_tlast,
    // digest words
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [TdataW-1:0]      m_axis_tdata,   // digest_word, word_index, zero pad
    output logic                   m_axis_tlast
);

    t_ctl        w_ctl;
    logic [31:0] w_w;
    logic [31:0] w_digest;

    s256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_data_word  (s_axis_tdata[DataW-1:0]),
        .i_byte_count (s_axis_tdata[DataW+CountW-1:DataW]),
        .i_last_word  (s_axis_tlast),
        .o_in_ready   (s_axis_tready),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_ctl        (w_ctl)
    );

    s256_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .o_w   (w_w)
    );

    s256_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_w      (w_w),
        .o_digest (w_digest)
    );

    // Output item
    assign m_axis_tdata = {{(TdataW - DataW - IndexW){1'b0}}, w_ctl.out_idx, w_digest};
    assign m_axis_tlast = (w_ctl.out_idx == LastIndex);

endmodule

`default_nettype wire

FILE: rtl/core/s256_chk.sv
// ----------------------------------------------------------------------------
// s256_chk
// Port-level checks of the hash engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module s256_chk
    import s256_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tready,
    input  wire logic              i_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire logic [TdataW-1:0] i_m_tdata,
    input  wire logic              i_m_tlast
);

    // No new message word is taken while digest words are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_m_tvalid && i_s_tready))
        else $error("input ready while digest pending");

    // tlast marks exactly the eighth digest word
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tlast == (i_m_tdata[DataW+IndexW-1:DataW] == LastIndex)))
        else $error("tlast does not match word index");

    // Digest words follow each other in index order without gaps
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tready && !i_m_tlast) |=>
        (i_m_tvalid && (i_m_tdata[DataW+IndexW-1:DataW] ==
                        $past(i_m_tdata[DataW+IndexW-1:DataW]) + 3'd1)))
        else $error("digest word index out of order");

    // After the final digest word the engine is idle again
    a_ready_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tready && i_m_tlast) |=> (i_s_tready && !i_m_tvalid))
        else $error("engine not idle after digest");

endmodule

bind sha256_hash_engine s256_chk u_s256_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast)
);

`default_nettype wire
